// File: rtl/core/cfd_pkg.sv
`timescale 1ns / 1ps

package cfd_pkg;

	localparam int unsigned CFD_MAX_DATA_BYTES = 8;
	localparam logic [7:0] CFD_MAX_LEN = 8'(CFD_MAX_DATA_BYTES);
	localparam int unsigned CFD_QUEUE_DEPTH = 4;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

	// What a byte means within a frame, as decided by the front end.
	typedef enum logic [2:0] {
		K_ID,
		K_LEN,
		K_LEN_ERR,
		K_DATA,
		K_CRC
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CRC_ERR = 2'd1,
		ST_LEN_ERR = 2'd2
	} status_t;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] idx;
		logic [7:0] data;
	} entry_t;

	typedef struct packed {
		logic [63:0] payload;
		logic [3:0]  pay_len;
		logic [31:0] frame_id;
		status_t     status;
	} result_t;

	// Reflected CRC-32, one byte, bit by bit.
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		int k;
		c = crc ^ {24'd0, b};
		for (k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/core/cfd_front.sv
`timescale 1ns / 1ps

module cfd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [7:0]      cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            q_full,
	output logic            push,
	output cfd_pkg::entry_t push_entry
);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_ID,
		PH_LEN,
		PH_DATA,
		PH_CRC
	} phase_t;

	phase_t     phase_q;
	logic [2:0] cnt_q;
	logic [3:0] len_q;
	logic [7:0] header_q;
	logic       beat;
	logic       len_bad;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign beat      = in_valid && in_ready;
	assign len_bad   = in_byte > cfd_pkg::CFD_MAX_LEN;
	assign push      = beat && (phase_q != PH_HUNT);

	always_comb begin
		push_entry.data = in_byte;
		push_entry.idx  = cnt_q;
		unique case (phase_q)
			PH_ID:   push_entry.kind = cfd_pkg::K_ID;
			PH_LEN:  push_entry.kind = len_bad ? cfd_pkg::K_LEN_ERR : cfd_pkg::K_LEN;
			PH_DATA: push_entry.kind = cfd_pkg::K_DATA;
			PH_CRC:  push_entry.kind = cfd_pkg::K_CRC;
			default: push_entry.kind = cfd_pkg::K_ID;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			cnt_q    <= '0;
			len_q    <= '0;
			header_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				header_q <= cfg_data;
			end
			if (beat) begin
				unique case (phase_q)
					PH_HUNT: begin
						if (in_byte == header_q) begin
							phase_q <= PH_ID;
							cnt_q   <= '0;
						end
					end
					PH_ID: begin
						if (cnt_q == 3'd3) begin
							phase_q <= PH_LEN;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
					PH_LEN: begin
						cnt_q <= '0;
						if (len_bad) begin
							phase_q <= PH_HUNT;
						end else begin
							len_q   <= in_byte[3:0];
							phase_q <= (in_byte == 8'd0) ? PH_CRC : PH_DATA;
						end
					end
					PH_DATA: begin
						if ({1'b0, cnt_q} + 4'd1 >= len_q) begin
							phase_q <= PH_CRC;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
					PH_CRC: begin
						if (cnt_q == 3'd3) begin
							phase_q <= PH_HUNT;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
					default: begin
						phase_q <= PH_HUNT;
						cnt_q   <= '0;
					end
				endcase
			end
		end
	end

	a_data_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> ({1'b0, cnt_q} < len_q))
		else $error("payload byte index past frame length");

endmodule

// File: rtl/core/cfd_queue.sv
`timescale 1ns / 1ps

module cfd_queue #(
	parameter int unsigned DEPTH = cfd_pkg::CFD_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cfd_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            rd_valid,
	output cfd_pkg::entry_t rd_entry
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cfd_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rd_valid)
		else $error("queue read while empty");

endmodule

// File: rtl/core/cfd_back.sv
`timescale 1ns / 1ps

module cfd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  cfd_pkg::entry_t  q_entry,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_ready,
	output cfd_pkg::result_t res
);

	logic [31:0] id_q;
	logic [63:0] pay_q;
	logic [31:0] crc_q;
	logic [23:0] rx_q;
	logic [3:0]  len_q;
	logic        out_valid_q;
	cfd_pkg::result_t out_q;

	logic        is_result;
	logic [31:0] rx_full;
	logic [7:0]  b;

	assign b         = q_entry.data;
	assign is_result = (q_entry.kind == cfd_pkg::K_LEN_ERR)
		|| ((q_entry.kind == cfd_pkg::K_CRC) && (q_entry.idx[1:0] == 2'd3));
	assign pop       = q_valid && (!is_result || !out_valid_q || res_ready);
	assign rx_full   = {b, rx_q};
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q        <= '0;
			pay_q       <= '0;
			crc_q       <= cfd_pkg::CRC_ONES;
			rx_q        <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				unique case (q_entry.kind)
					cfd_pkg::K_ID: begin
						id_q[8*q_entry.idx[1:0] +: 8] <= b;
					end
					cfd_pkg::K_LEN: begin
						len_q <= b[3:0];
					end
					cfd_pkg::K_DATA: begin
						pay_q[8*q_entry.idx +: 8] <= b;
						crc_q <= cfd_pkg::crc32_byte(crc_q, b);
					end
					cfd_pkg::K_CRC: begin
						if (q_entry.idx[1:0] != 2'd3) begin
							rx_q[8*q_entry.idx[1:0] +: 8] <= b;
						end
					end
					default: begin
					end
				endcase
				if (is_result) begin
					out_valid_q <= 1'b1;
					out_q.frame_id <= id_q;
					if (q_entry.kind == cfd_pkg::K_LEN_ERR) begin
						out_q.status  <= cfd_pkg::ST_LEN_ERR;
						out_q.pay_len <= (b > 8'd15) ? 4'd15 : b[3:0];
						out_q.payload <= '0;
					end else begin
						out_q.status  <= (rx_full == ~crc_q) ? cfd_pkg::ST_OK
							: cfd_pkg::ST_CRC_ERR;
						out_q.pay_len <= len_q;
						out_q.payload <= pay_q;
					end
					// Frame done: start the next one from a clean slate.
					id_q  <= '0;
					pay_q <= '0;
					crc_q <= cfd_pkg::CRC_ONES;
					rx_q  <= '0;
					len_q <= '0;
				end
			end
		end
	end

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && is_result) |=> out_valid_q)
		else $error("frame result lost on its way to the output register");

endmodule

// File: rtl/core/can_frame_deframer_crc32.sv
`timescale 1ns / 1ps

// Byte-stream deframer with CRC-32 check. One byte is taken per beat on the
// slave side, one byte per clock cycle sustained while the master side takes
// the results. A front end hunts for the header byte and tags every frame byte
// with its role (identifier, length, payload, CRC); a queue of QUEUE_DEPTH
// entries decouples it from the back end, which assembles the fields, runs the
// reflected CRC-32 one byte per cycle and writes one result per frame into an
// output register. The last CRC byte (or an oversized length byte) is queued;
// once it is popped, its result is loaded into the output register. While a
// result waits to be taken the input keeps flowing until the final byte of the
// next frame reaches the back end and the queue fills behind it. The header
// value is written through the cfg channel; the user must write it only while
// the stream is idle, which the block does not enforce. It resets to zero.
module can_frame_deframer_crc32 #(
	parameter int unsigned QUEUE_DEPTH = cfd_pkg::CFD_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // in_byte[7:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata    // status[1:0], frame_id[33:2],
	                                     // pay_len[37:34], payload[101:38], zero
);

	logic             q_full;
	logic             push;
	cfd_pkg::entry_t  push_entry;
	logic             pop;
	logic             q_valid;
	cfd_pkg::entry_t  q_entry;
	cfd_pkg::result_t res;

	cfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	cfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.rd_valid   (q_valid),
		.rd_entry   (q_entry)
	);

	cfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.pop       (pop),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {2'b00, res.payload, res.pay_len, res.frame_id, res.status};

endmodule

// File: bench/cfd_frame_checker.sv
`timescale 1ns / 1ps

package cfd_tb_pkg;

	localparam logic [31:0] CRC32_REFLECTED_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC32_SEED = 32'hFFFFFFFF;

	// Shifts one byte into a reflected CRC-32, least significant bit first.
	function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] r;
		logic fb;
		int i;
		r = crc;
		for (i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = {1'b0, r[31:1]} ^ (fb ? CRC32_REFLECTED_POLY : 32'h0);
		end
		return r;
	endfunction

endpackage

module cfd_frame_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [7:0]   cfg_data,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // in_byte[7:0]
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [103:0] m_axis_tdata,   // status[1:0], frame_id[33:2],
	                                     // pay_len[37:34], payload[101:38], zero
	output int unsigned  mismatches,
	output int unsigned  frames_due,
	output logic         hunting
);

	typedef enum logic [2:0] {
		SEEK_HEADER,
		TAKE_ID,
		TAKE_LEN,
		TAKE_DATA,
		TAKE_CRC
	} deframe_stage_t;

	logic [7:0]       header_q;
	deframe_stage_t   stage_q;
	logic [2:0]       field_idx;
	logic [31:0]      id_acc;
	logic [3:0]       len_q;
	logic [63:0]      payload_acc;
	logic [31:0]      crc_acc;
	logic [31:0]      crc_rx;
	cfd_pkg::result_t expected_frames[$];

	assign hunting = (stage_q == SEEK_HEADER);

	task automatic restart();
		stage_q = SEEK_HEADER;
		field_idx = 3'd0;
		id_acc = 32'h0;
		len_q = 4'd0;
		payload_acc = 64'h0;
		crc_acc = cfd_tb_pkg::CRC32_SEED;
		crc_rx = 32'h0;
	endtask

	task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t ns frame mismatch on %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	// Advances the predicted deframer by one beat and queues any frame it completes.
	task automatic absorb_byte(input logic [7:0] b);
		cfd_pkg::result_t r;
		case (stage_q)
		SEEK_HEADER: begin
			if (b == header_q) begin
				restart();
				stage_q = TAKE_ID;
			end
		end
		TAKE_ID: begin
			id_acc[int'(field_idx) * 8 +: 8] = b;
			if (field_idx == 3'd3) begin
				field_idx = 3'd0;
				stage_q = TAKE_LEN;
			end else begin
				field_idx++;
			end
		end
		TAKE_LEN: begin
			if (b > cfd_pkg::CFD_MAX_LEN) begin
				r.status = cfd_pkg::ST_LEN_ERR;
				r.frame_id = id_acc;
				r.pay_len = (b > 8'd15) ? 4'd15 : b[3:0];
				r.payload = 64'h0;
				expected_frames.push_back(r);
				restart();
			end else begin
				len_q = b[3:0];
				field_idx = 3'd0;
				stage_q = (b == 8'd0) ? TAKE_CRC : TAKE_DATA;
			end
		end
		TAKE_DATA: begin
			payload_acc[int'(field_idx) * 8 +: 8] = b;
			crc_acc = cfd_tb_pkg::crc32_step(crc_acc, b);
			if (4'(field_idx) + 4'd1 >= len_q) begin
				field_idx = 3'd0;
				stage_q = TAKE_CRC;
			end else begin
				field_idx++;
			end
		end
		TAKE_CRC: begin
			crc_rx[int'(field_idx) * 8 +: 8] = b;
			if (field_idx == 3'd3) begin
				r.status = (crc_rx == ~crc_acc) ? cfd_pkg::ST_OK : cfd_pkg::ST_CRC_ERR;
				r.frame_id = id_acc;
				r.pay_len = len_q;
				r.payload = payload_acc;
				expected_frames.push_back(r);
				restart();
			end else begin
				field_idx++;
			end
		end
		default: begin
			restart();
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		cfd_pkg::result_t seen;
		cfd_pkg::result_t want;
		if (!arst_n) begin
			header_q = 8'h00;
			restart();
			expected_frames.delete();
			mismatches = 0;
			frames_due = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen = m_axis_tdata[101:0];
				if (expected_frames.size() == 0) begin
					flag("unexpected result", m_axis_tdata[63:0], 64'h0);
				end else begin
					want = expected_frames.pop_front();
					if (seen.status !== want.status)
						flag("status", 64'(seen.status), 64'(want.status));
					if (seen.frame_id !== want.frame_id)
						flag("frame_id", 64'(seen.frame_id), 64'(want.frame_id));
					if (seen.pay_len !== want.pay_len)
						flag("pay_len", 64'(seen.pay_len), 64'(want.pay_len));
					if (seen.payload !== want.payload)
						flag("payload", seen.payload, want.payload);
					if (m_axis_tdata[103:102] !== 2'b00)
						flag("padding", 64'(m_axis_tdata[103:102]), 64'h0);
				end
			end
			if (cfg_valid && cfg_ready)
				header_q = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				absorb_byte(s_axis_tdata);
			frames_due = expected_frames.size();
		end
	end

endmodule

// File: bench/tb_can_frame_deframer_crc32.sv
`timescale 1ns / 1ps

module tb_can_frame_deframer_crc32;

	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned PHASE_BYTES = 185;
	localparam int unsigned SETTLE_CYCLES = 16;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [7:0]   cfg_data = 8'h00;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;   // in_byte[7:0]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;           // status[1:0], frame_id[33:2],
	                                      // pay_len[37:34], payload[101:38], zero

	int unsigned  mismatches;
	int unsigned  frames_due;
	logic         hunting;

	logic [7:0]   header = 8'h00;
	int unsigned  burst_left = 0;
	int unsigned  bytes_sent = 0;
	int unsigned  idle_cycles = 0;
	bit           hold_req = 1'b0;

	always #5 clk = ~clk;

	can_frame_deframer_crc32 dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	cfd_frame_checker frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.mismatches(mismatches),
		.frames_due(frames_due),
		.hunting(hunting)
	);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_can_frame_deframer_crc32 failed");
			$finish;
		end
	end

	// The result side runs its own stall pattern and honors a long hold-off on request.
	initial begin : sink
		int unsigned mode;
		int unsigned span;
		int unsigned k;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk) m_axis_tready <= 1'b0;
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 96);
			for (k = 0; k < span; k++) begin
				@(negedge clk);
				case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ((k % 7) < 2);
				default: m_axis_tready <= ((k & 15) == 15);
				endcase
			end
		end
	end

	// Offers one beat, inserting a random gap whenever a burst runs out.
	task automatic put_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 32);
			repeat (gap) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		bytes_sent++;
	endtask

	// Feeds non-header filler until the checker's predicted deframer is back to hunting, then stops offering.
	task automatic drain_to_hunt();
		forever begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			if (hunting)
				break;
			put_byte((header == 8'hFF) ? 8'hFE : 8'hFF);
		end
	endtask

	task automatic set_header(input logic [7:0] value);
		while (frames_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		header = value;
		burst_left = 0;
	endtask

	// Frame content, with the header value turning up inside frames now and then.
	function automatic logic [7:0] pick_byte();
		return ($urandom_range(0, 7) == 0) ? header : 8'($urandom_range(0, 255));
	endfunction

	task automatic send_frame(input bit crc_bad, input bit len_bad);
		logic [7:0]  n;
		logic [7:0]  b;
		logic [31:0] crc;
		int          i;
		put_byte(header);
		for (i = 0; i < 4; i++)
			put_byte(pick_byte());
		if (len_bad) begin
			case ($urandom_range(0, 4))
			0: n = 8'd9;
			1: n = 8'd15;
			2: n = 8'd16;
			3: n = 8'd255;
			default: n = 8'($urandom_range(9, 255));
			endcase
			put_byte(n);
			return;
		end
		n = 8'($urandom_range(0, 8));
		put_byte(n);
		crc = cfd_tb_pkg::CRC32_SEED;
		for (i = 0; i < n; i++) begin
			b = pick_byte();
			crc = cfd_tb_pkg::crc32_step(crc, b);
			put_byte(b);
		end
		crc = ~crc;
		if (crc_bad)
			crc ^= 32'h1 << $urandom_range(0, 31);
		for (i = 0; i < 4; i++)
			put_byte(crc[i * 8 +: 8]);
	endtask

	// Mostly well-formed frames, with bad CRCs, oversized lengths, cut-off frames and stray bytes.
	task automatic random_traffic(input int unsigned budget);
		int unsigned start;
		int unsigned r;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				put_byte(8'($urandom_range(0, 255)));
			end else if (r < 12) begin
				put_byte(header);
				repeat ($urandom_range(0, 5)) put_byte(8'($urandom_range(0, 255)));
			end else begin
				send_frame(r < 22, (r >= 22) && (r < 32));
			end
		end
		drain_to_hunt();
	endtask

	initial begin
		logic [7:0] headers [6];
		int         p;
		headers = '{8'hFF, 8'($urandom_range(0, 255)), 8'h00,
		            8'($urandom_range(0, 255)), 8'hA5, 8'($urandom_range(0, 255))};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset header of zero: a stray byte, an oversized length, an empty frame
		// whose CRC is that of no data, and a length just past the maximum with
		// header values inside the identifier.
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(8'h01); put_byte(8'h02); put_byte(8'h03); put_byte(8'h04);
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(8'h00); put_byte(8'h00); put_byte(8'h00); put_byte(8'h00);
		put_byte(8'h00);
		put_byte(8'h00); put_byte(8'h00); put_byte(8'h00); put_byte(8'h00);
		put_byte(8'h09);
		drain_to_hunt();

		for (p = 0; p < 6; p++) begin
			set_header(headers[p]);
			if (p == 0 || p == 3) begin
				@(posedge clk);
				hold_req = 1'b1;
			end
			random_traffic(PHASE_BYTES);
		end

		while (frames_due != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("tb_can_frame_deframer_crc32 passed");
		else
			$display("tb_can_frame_deframer_crc32 failed");
		$finish;
	end

endmodule
